// ===== rtl/core/tkbwn_pkg.sv =====
// Shared types and constants for the top-k bone weight normaliser.
package tkbwn_pkg;

    localparam int BONE_W    = 8;
    localparam int WEIGHT_W  = 16;
    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [WEIGHT_W-1:0] Q_ONE = 16'd32768;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_NORM  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_REPLACE,
        ST_PAD,
        ST_SUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic fill;
        logic scan;
        logic replace;
        logic pad;
        logic sum_add;
        logic idx_clear;
        logic idx_inc;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic idx_last;
        logic div_last;
        logic out_busy;
        logic zero;
    } status_t;

endpackage

// ===== rtl/core/tkbwn_div.sv =====
// Restoring divider: one quotient bit per cycle while step is high, for floor(w * 32768 / sum).
module tkbwn_div #(
    parameter int SW = 19
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic                               step,
    input  logic [tkbwn_pkg::WEIGHT_W-1:0]     dividend_w,
    input  logic [SW-1:0]                      divisor,
    output logic [tkbwn_pkg::WEIGHT_W-1:0]     quotient,
    output logic                               last
);

    logic [SW-1:0]                     rem_reg,  rem_next;
    logic [tkbwn_pkg::WEIGHT_W-1:0]    bits_reg, bits_next;
    logic [tkbwn_pkg::WEIGHT_W-1:0]    quo_reg,  quo_next;
    logic [tkbwn_pkg::CNT_W-1:0]       cnt_reg,  cnt_next;
    logic [SW:0]                       trial;
    logic [SW:0]                       diff;
    logic                              ge;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, bits_reg[tkbwn_pkg::WEIGHT_W-1]};
    assign ge    = (trial >= {1'b0, divisor});
    assign diff  = trial - {1'b0, divisor};

    // Load w * 32768 split as high part (w >> 1) and low bits, or advance one bit
    always_comb
    begin
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            rem_next  = {{(SW-tkbwn_pkg::WEIGHT_W+1){1'b0}},
                         dividend_w[tkbwn_pkg::WEIGHT_W-1:1]};
            bits_next = {dividend_w[0], {(tkbwn_pkg::WEIGHT_W-1){1'b0}}};
            quo_next  = '0;
            cnt_next  = '0;
        end
        else if (step)
        begin
            rem_next  = ge ? diff[SW-1:0] : trial[SW-1:0];
            bits_next = {bits_reg[tkbwn_pkg::WEIGHT_W-2:0], 1'b0};
            quo_next  = {quo_reg[tkbwn_pkg::WEIGHT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == tkbwn_pkg::CNT_W'(tkbwn_pkg::DIV_STEPS - 1));

endmodule

// ===== rtl/core/tkbwn_dp.sv =====
// Datapath: slot store, lightest-slot scan, weight sum, divider and output register.
module tkbwn_dp #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tkbwn_pkg::cmd_t                    cmd,
    output tkbwn_pkg::status_t                 status,
    input  logic [tkbwn_pkg::BONE_W-1:0]       bone_index,
    input  logic [tkbwn_pkg::WEIGHT_W-1:0]     weight,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [tkbwn_pkg::BONE_W-1:0]       bone_index_out,
    output logic [tkbwn_pkg::WEIGHT_W-1:0]     weight_out,
    output logic                               slot_real,
    output logic                               zero_sum,
    output logic                               last
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FW = $clog2(SLOT_COUNT + 1);
    localparam int SW = tkbwn_pkg::WEIGHT_W + 1 + $clog2(SLOT_COUNT);

    logic [tkbwn_pkg::BONE_W-1:0]   slot_bone_reg   [SLOT_COUNT];
    logic [tkbwn_pkg::WEIGHT_W-1:0] slot_weight_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]          slot_real_reg;
    logic [FW-1:0]                  filled_reg;
    logic [IW-1:0]                  idx_reg;
    logic [tkbwn_pkg::BONE_W-1:0]   item_bone_reg;
    logic [tkbwn_pkg::WEIGHT_W-1:0] item_weight_reg;
    logic [IW-1:0]                  light_at_reg;
    logic [tkbwn_pkg::WEIGHT_W-1:0] light_w_reg;
    logic [SW-1:0]                  sum_reg;

    logic                           out_valid_reg;
    logic [tkbwn_pkg::BONE_W-1:0]   out_bone_reg;
    logic [tkbwn_pkg::WEIGHT_W-1:0] out_weight_reg;
    logic                           out_real_reg;
    logic                           out_zero_reg;
    logic                           out_last_reg;

    logic [tkbwn_pkg::BONE_W-1:0]   rd_bone;
    logic [tkbwn_pkg::WEIGHT_W-1:0] rd_weight;
    logic [tkbwn_pkg::WEIGHT_W-1:0] quotient;
    logic [tkbwn_pkg::WEIGHT_W-1:0] norm_weight;
    logic                           div_last;
    logic                           idx_last;
    logic                           zero;
    logic                           wr_en;
    logic                           wr_bone_en;
    logic [IW-1:0]                  wr_addr;
    logic [tkbwn_pkg::BONE_W-1:0]   wr_bone;
    logic [tkbwn_pkg::WEIGHT_W-1:0] wr_weight;

    // Read port at the running slot index
    assign rd_bone     = slot_bone_reg[idx_reg];
    assign rd_weight   = slot_weight_reg[idx_reg];
    assign idx_last    = (idx_reg == IW'(SLOT_COUNT - 1));
    assign zero        = (sum_reg == '0);
    assign norm_weight = zero ? '0 : quotient;

    // Select the single slot write: fill, replace-lightest or write-back
    always_comb
    begin
        wr_en      = 1'b0;
        wr_bone_en = 1'b0;
        wr_addr    = idx_reg;
        wr_bone    = item_bone_reg;
        wr_weight  = item_weight_reg;
        if (cmd.fill)
        begin
            wr_en      = 1'b1;
            wr_bone_en = 1'b1;
            wr_addr    = filled_reg[IW-1:0];
        end
        else if (cmd.replace)
        begin
            wr_en      = (item_weight_reg > light_w_reg);
            wr_bone_en = 1'b1;
            wr_addr    = light_at_reg;
        end
        else if (cmd.out_load)
        begin
            wr_en     = 1'b1;
            wr_weight = norm_weight;
        end
    end

    // Slot payload: pad unfilled slots with dummies, otherwise take the write
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (cmd.pad && (FW'(i) >= filled_reg))
            begin
                slot_bone_reg[i]   <= '0;
                slot_weight_reg[i] <= '0;
            end
            else if (wr_en && (wr_addr == IW'(i)))
            begin
                if (wr_bone_en)
                begin
                    slot_bone_reg[i] <= wr_bone;
                end
                slot_weight_reg[i] <= wr_weight;
            end
        end
    end

    // Real-slot flags, fill count and slot index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_real_reg <= '0;
            filled_reg    <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                slot_real_reg <= '0;
                filled_reg    <= '0;
            end
            else if (cmd.pad)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (FW'(i) >= filled_reg)
                    begin
                        slot_real_reg[i] <= 1'b0;
                    end
                end
                filled_reg <= FW'(SLOT_COUNT);
            end
            else
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (wr_en && wr_bone_en && (wr_addr == IW'(i)))
                    begin
                        slot_real_reg[i] <= 1'b1;
                    end
                end
                if (cmd.fill)
                begin
                    filled_reg <= filled_reg + 1'b1;
                end
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Latch the add item with its weight saturated to one
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_bone_reg   <= bone_index;
            item_weight_reg <= (weight > tkbwn_pkg::Q_ONE) ? tkbwn_pkg::Q_ONE : weight;
        end
    end

    // Track the lightest slot, first one on ties
    always_ff @(posedge clk)
    begin
        if (cmd.scan && ((idx_reg == '0) || (rd_weight < light_w_reg)))
        begin
            light_at_reg <= idx_reg;
            light_w_reg  <= rd_weight;
        end
    end

    // Accumulate the weight sum one slot a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.pad)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_add)
        begin
            sum_reg <= sum_reg + SW'(rd_weight);
        end
    end

    tkbwn_div #(
        .SW (SW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (cmd.div_load),
        .step       (cmd.div_step),
        .dividend_w (rd_weight),
        .divisor    (sum_reg),
        .quotient   (quotient),
        .last       (div_last)
    );

    // Output register: hold while stalled, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_bone_reg   <= rd_bone;
            out_weight_reg <= norm_weight;
            out_real_reg   <= slot_real_reg[idx_reg];
            out_zero_reg   <= zero;
            out_last_reg   <= idx_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bone_index_out = out_bone_reg;
    assign weight_out     = out_weight_reg;
    assign slot_real      = out_real_reg;
    assign zero_sum       = out_zero_reg;
    assign last           = out_last_reg;

    assign status.full     = (filled_reg == FW'(SLOT_COUNT));
    assign status.idx_last = idx_last;
    assign status.div_last = div_last;
    assign status.out_busy = out_valid_reg && out_stall;
    assign status.zero     = zero;

endmodule

// ===== rtl/core/tkbwn_ctrl.sv =====
// Controller: sequences add, normalise and clear transactions over the datapath.
module tkbwn_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            op,
    input  tkbwn_pkg::status_t    status,
    output tkbwn_pkg::cmd_t       cmd
);

    tkbwn_pkg::state_t state_reg, state_next;
    logic              accept;

    assign accept = (state_reg == tkbwn_pkg::ST_IDLE) && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkbwn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkbwn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        tkbwn_pkg::OP_ADD:
                            state_next = status.full ? tkbwn_pkg::ST_SCAN : tkbwn_pkg::ST_FILL;
                        tkbwn_pkg::OP_NORM:
                            state_next = tkbwn_pkg::ST_PAD;
                        default:
                            state_next = tkbwn_pkg::ST_IDLE;
                    endcase
                end
            end
            tkbwn_pkg::ST_FILL:
                state_next = tkbwn_pkg::ST_IDLE;
            tkbwn_pkg::ST_SCAN:
                if (status.idx_last)
                begin
                    state_next = tkbwn_pkg::ST_REPLACE;
                end
            tkbwn_pkg::ST_REPLACE:
                state_next = tkbwn_pkg::ST_IDLE;
            tkbwn_pkg::ST_PAD:
                state_next = tkbwn_pkg::ST_SUM;
            tkbwn_pkg::ST_SUM:
                if (status.idx_last)
                begin
                    state_next = tkbwn_pkg::ST_DIV_LOAD;
                end
            tkbwn_pkg::ST_DIV_LOAD:
                state_next = status.zero ? tkbwn_pkg::ST_OUT : tkbwn_pkg::ST_DIV;
            tkbwn_pkg::ST_DIV:
                if (status.div_last)
                begin
                    state_next = tkbwn_pkg::ST_OUT;
                end
            tkbwn_pkg::ST_OUT:
                if (!status.out_busy)
                begin
                    state_next = status.idx_last ? tkbwn_pkg::ST_IDLE
                                                 : tkbwn_pkg::ST_DIV_LOAD;
                end
            default:
                state_next = tkbwn_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.clear     = accept && (op == tkbwn_pkg::OP_CLEAR);
        cmd.idx_clear = accept;
        in_stall      = (state_reg != tkbwn_pkg::ST_IDLE);
        unique case (state_reg)
            tkbwn_pkg::ST_IDLE:
            begin
            end
            tkbwn_pkg::ST_FILL:
                cmd.fill = 1'b1;
            tkbwn_pkg::ST_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.idx_inc = !status.idx_last;
            end
            tkbwn_pkg::ST_REPLACE:
                cmd.replace = 1'b1;
            tkbwn_pkg::ST_PAD:
                cmd.pad = 1'b1;
            tkbwn_pkg::ST_SUM:
            begin
                cmd.sum_add   = 1'b1;
                cmd.idx_inc   = !status.idx_last;
                cmd.idx_clear = status.idx_last;
            end
            tkbwn_pkg::ST_DIV_LOAD:
                cmd.div_load = 1'b1;
            tkbwn_pkg::ST_DIV:
                cmd.div_step = 1'b1;
            tkbwn_pkg::ST_OUT:
            begin
                cmd.out_load = !status.out_busy;
                cmd.idx_inc  = !status.out_busy && !status.idx_last;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/top_k_bone_weight_normalizer_unit.sv =====
// Top level of the top-k bone weight normaliser: controller, datapath and checks.
//
// Usage: one input channel (in_valid / in_stall) carries op, bone_index and
// weight; one output channel (out_valid / out_stall) carries one slot result
// per transaction. op add keeps the SLOT_COUNT heaviest influences of the
// current vertex, op normalise emits SLOT_COUNT results (last on the final
// one), op clear starts a new vertex; op 3 is ignored.
// Sequence: an add writes a free slot directly, or else scans every slot for
// the lightest one and replaces it if the new weight is heavier. A normalise
// is accepted, pads and sums the slots, then for each slot loads the divider,
// steps it bit by bit and outputs the result; with a zero sum the divider is
// skipped. A clear completes as it is accepted.
// A new transaction is accepted once the previous one is finished, even if
// its last result still sits in the output register.
// Reset empties the store and the output register; no clearing pass is run.
// When the receiver stalls, the result holds and the next divide waits for it.
module top_k_bone_weight_normalizer_unit #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         op,
    input  logic [tkbwn_pkg::BONE_W-1:0]       bone_index,
    input  logic [tkbwn_pkg::WEIGHT_W-1:0]     weight,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tkbwn_pkg::BONE_W-1:0]       bone_index_out,
    output logic [tkbwn_pkg::WEIGHT_W-1:0]     weight_out,
    output logic                               slot_real,
    output logic                               zero_sum,
    output logic                               last
);

    tkbwn_pkg::cmd_t    cmd;
    tkbwn_pkg::status_t status;

    tkbwn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    tkbwn_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .bone_index     (bone_index),
        .weight         (weight),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .bone_index_out (bone_index_out),
        .weight_out     (weight_out),
        .slot_real      (slot_real),
        .zero_sum       (zero_sum),
        .last           (last)
    );

    // Never overwrite a result that the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.out_busy)
        else $error("output register overwritten while stalled");

    // Store and divider writes are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fill, cmd.replace, cmd.pad, cmd.sum_add,
                  cmd.div_load, cmd.div_step, cmd.out_load}))
        else $error("conflicting datapath commands");

    // The slot index never runs past the last slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_inc |-> !status.idx_last)
        else $error("slot index overrun");

    // A divide run ends in the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && status.div_last) |=> (!cmd.div_step && !cmd.accept))
        else $error("divider stepped past its final bit");

endmodule

// ===== verif/top_k_bone_weight_normalizer_unit_test.sv =====
// Self-checking testbench for the top-k bone weight normaliser unit.
`timescale 1ns / 1ps

module top_k_bone_weight_normalizer_unit_test;

    localparam int SLOTS          = 4;
    localparam int RANDOM_ITEMS   = 300;
    localparam int TAIL_ITEMS     = 40;
    localparam int HOLD_AFTER     = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    // op 3 has no name in the package; the block ignores it
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct {
        logic [1:0]                     op;
        logic [tkbwn_pkg::BONE_W-1:0]   bone;
        logic [tkbwn_pkg::WEIGHT_W-1:0] weight;
        bit                             drain_first;
    } stim_item_t;

    typedef struct packed {
        logic [tkbwn_pkg::BONE_W-1:0]   bone;
        logic [tkbwn_pkg::WEIGHT_W-1:0] weight;
        logic                           is_real;
        logic                           zero;
        logic                           last;
    } slot_result_t;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic [1:0]                     op         = tkbwn_pkg::OP_ADD;
    logic [tkbwn_pkg::BONE_W-1:0]   bone_index = '0;
    logic [tkbwn_pkg::WEIGHT_W-1:0] weight     = '0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic [tkbwn_pkg::BONE_W-1:0]   bone_index_out;
    logic [tkbwn_pkg::WEIGHT_W-1:0] weight_out;
    logic                           slot_real;
    logic                           zero_sum;
    logic                           last;

    top_k_bone_weight_normalizer_unit #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .bone_index     (bone_index),
        .weight         (weight),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bone_index_out (bone_index_out),
        .weight_out     (weight_out),
        .slot_real      (slot_real),
        .zero_sum       (zero_sum),
        .last           (last)
    );

    // Predicted contents of the influence store
    logic [tkbwn_pkg::BONE_W-1:0]   store_bone   [SLOTS];
    logic [tkbwn_pkg::WEIGHT_W-1:0] store_weight [SLOTS];
    logic                           store_used   [SLOTS];
    int unsigned                    store_count;

    stim_item_t   pending_items[$];
    slot_result_t expected_slot_results[$];

    int unsigned mismatches = 0;
    int unsigned accepted_inputs = 0;
    logic        tail_phase = 1'b0;

    // Driver and receiver working variables
    int unsigned send_gap_left = 0;
    stim_item_t  next_item;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 0;
    logic        next_stall;
    int unsigned idle_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the predicted store by one accepted transaction
    task automatic update_influences(input logic [1:0] item_op,
                                     input logic [tkbwn_pkg::BONE_W-1:0] item_bone,
                                     input logic [tkbwn_pkg::WEIGHT_W-1:0] item_weight);
        logic [tkbwn_pkg::WEIGHT_W-1:0] w;
        int unsigned                    light_at;
        int unsigned                    sum;
        int unsigned                    q;
        slot_result_t                   res;
        begin
            case (item_op)
                tkbwn_pkg::OP_ADD:
                begin
                    w = (item_weight > tkbwn_pkg::Q_ONE) ? tkbwn_pkg::Q_ONE : item_weight;
                    if (store_count < SLOTS)
                    begin
                        store_bone[store_count]   = item_bone;
                        store_weight[store_count] = w;
                        store_used[store_count]   = 1'b1;
                        store_count++;
                    end
                    else
                    begin
                        // lightest slot, first one on ties
                        light_at = 0;
                        for (int i = 1; i < SLOTS; i++)
                            if (store_weight[i] < store_weight[light_at])
                                light_at = i;
                        if (w > store_weight[light_at])
                        begin
                            store_bone[light_at]   = item_bone;
                            store_weight[light_at] = w;
                            store_used[light_at]   = 1'b1;
                        end
                    end
                end
                tkbwn_pkg::OP_NORM:
                begin
                    // pad free slots with dummy entries
                    for (int i = store_count; i < SLOTS; i++)
                    begin
                        store_bone[i]   = '0;
                        store_weight[i] = '0;
                        store_used[i]   = 1'b0;
                    end
                    store_count = SLOTS;
                    sum = 0;
                    for (int i = 0; i < SLOTS; i++)
                        sum += store_weight[i];
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        q = (sum == 0) ? 0 :
                            (int'(store_weight[i]) * int'(tkbwn_pkg::Q_ONE)) / sum;
                        store_weight[i] = q[tkbwn_pkg::WEIGHT_W-1:0];
                        res.bone    = store_bone[i];
                        res.weight  = q[tkbwn_pkg::WEIGHT_W-1:0];
                        res.is_real = store_used[i];
                        res.zero    = (sum == 0);
                        res.last    = (i == SLOTS - 1);
                        expected_slot_results = {expected_slot_results, res};
                    end
                end
                tkbwn_pkg::OP_CLEAR:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        store_bone[i]   = '0;
                        store_weight[i] = '0;
                        store_used[i]   = 1'b0;
                    end
                    store_count = 0;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic queue_item(input logic [1:0] item_op, input int item_bone,
                              input int item_weight, input bit drain = 0);
        stim_item_t it;
        begin
            it.op          = item_op;
            it.bone        = item_bone[tkbwn_pkg::BONE_W-1:0];
            it.weight      = item_weight[tkbwn_pkg::WEIGHT_W-1:0];
            it.drain_first = drain;
            pending_items = {pending_items, it};
        end
    endtask

    // Weights biased towards ties, extremes and values above one
    function automatic int pick_weight(input bit all_zero);
        int sel;
        begin
            sel = $urandom_range(0, 9);
            if (all_zero)
                pick_weight = 0;
            else if (sel == 0)
                pick_weight = $urandom_range(0, 65535);
            else if (sel == 1)
                pick_weight = ($urandom_range(0, 1) == 0) ? 0 : 32768;
            else if (sel <= 3)
                pick_weight = 100 * $urandom_range(1, 3);
            else
                pick_weight = $urandom_range(0, 32768);
        end
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        begin
            if (exp_val != act_val)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $realtime, name, exp_val, act_val);
                mismatches++;
            end
        end
    endtask

    // Driver: present pending items, hold each until the block takes it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            op            <= tkbwn_pkg::OP_ADD;
            bone_index    <= '0;
            weight        <= '0;
            send_gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                update_influences(op, bone_index, weight);
                accepted_inputs <= accepted_inputs + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap_left > 0)
                begin
                    send_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_items[0].drain_first &&
                         expected_slot_results.size() != 0)
                    in_valid <= 1'b0;
                else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
                begin
                    send_gap_left = $urandom_range(1, 10) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_item = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    op         <= next_item.op;
                    bone_index <= next_item.bone;
                    weight     <= next_item.weight;
                end
            end
            tail_phase <= (pending_items.size() <= TAIL_ITEMS);
        end
    end

    // Receiver: random stall bursts and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 0;
        end
        else
        begin
            if (!hold_done && accepted_inputs >= HOLD_AFTER && out_valid)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (tail_phase)
                next_stall = 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                next_stall = 1'b1;
            end
            else
                next_stall = 1'b0;
            out_stall <= next_stall;
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_slot_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual bone %0d weight %0d",
                         $realtime, bone_index_out, weight_out);
                mismatches++;
            end
            else
            begin
                automatic slot_result_t exp_res = expected_slot_results.pop_front();
                check_field("bone_index_out", exp_res.bone, bone_index_out);
                check_field("weight_out", exp_res.weight, weight_out);
                check_field("slot_real", exp_res.is_real, slot_real);
                check_field("zero_sum", exp_res.zero, zero_sum);
                check_field("last", exp_res.last, last);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int  random_count;
        int  n_adds;
        bit  zero_vertex;
        bit  drain_set;
        random_count = 0;
        drain_set    = 0;

        // Directed: empty store, saturation, padding, repeats
        queue_item(tkbwn_pkg::OP_NORM, 'hFF, 'hFFFF);
        queue_item(tkbwn_pkg::OP_ADD, 'hFF, 'hFFFF);
        queue_item(tkbwn_pkg::OP_ADD, 'h00, 'h0000);
        queue_item(tkbwn_pkg::OP_NORM, 0, 0);
        queue_item(tkbwn_pkg::OP_NORM, 0, 0);
        queue_item(tkbwn_pkg::OP_CLEAR, 'hFF, 'hFFFF);
        // Directed: replace-lightest, equal weight, first-on-ties
        queue_item(tkbwn_pkg::OP_ADD, 'h01, 'h8000);
        queue_item(tkbwn_pkg::OP_ADD, 'h80, 'h5555);
        queue_item(tkbwn_pkg::OP_ADD, 'hAA, 'h2AAA);
        queue_item(tkbwn_pkg::OP_ADD, 'h55, 'h5555);
        queue_item(tkbwn_pkg::OP_ADD, 'h33, 'h2AAA);
        queue_item(tkbwn_pkg::OP_ADD, 'h44, 'h2AAB);
        queue_item(tkbwn_pkg::OP_ADD, 'h66, 'h5556);
        queue_item(tkbwn_pkg::OP_ADD, 'h77, 'h6000);
        queue_item(OP_IGNORED, 'hFF, 'hFFFF);
        queue_item(tkbwn_pkg::OP_NORM, 0, 0);
        // Directed: adds after a padded normalise go through replace
        queue_item(tkbwn_pkg::OP_CLEAR, 0, 0);
        queue_item(tkbwn_pkg::OP_ADD, 'h12, 'h0100);
        queue_item(tkbwn_pkg::OP_NORM, 0, 0);
        queue_item(tkbwn_pkg::OP_ADD, 'h34, 'h0001);
        queue_item(tkbwn_pkg::OP_NORM, 0, 0);
        queue_item(tkbwn_pkg::OP_CLEAR, 0, 0);
        queue_item(tkbwn_pkg::OP_NORM, 0, 0);

        // Random: mostly whole vertices, some noise and broken sequences
        while (random_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: queue_item(OP_IGNORED, $urandom, $urandom);
                    1:
                    begin
                        queue_item(tkbwn_pkg::OP_NORM, $urandom, $urandom);
                        random_count++;
                    end
                    default:
                    begin
                        queue_item(tkbwn_pkg::OP_CLEAR, $urandom, $urandom);
                        random_count++;
                    end
                endcase
            end
            else
            begin
                zero_vertex = ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 7) != 0)
                begin
                    queue_item(tkbwn_pkg::OP_CLEAR, $urandom, $urandom,
                               !drain_set && random_count >= RANDOM_ITEMS / 2);
                    if (random_count >= RANDOM_ITEMS / 2)
                        drain_set = 1;
                    random_count++;
                end
                n_adds = $urandom_range(1, 7);
                for (int i = 0; i < n_adds; i++)
                    queue_item(tkbwn_pkg::OP_ADD, $urandom, pick_weight(zero_vertex));
                random_count += n_adds;
                queue_item(tkbwn_pkg::OP_NORM, $urandom, $urandom);
                random_count++;
                if ($urandom_range(0, 3) == 0)
                begin
                    queue_item(tkbwn_pkg::OP_NORM, $urandom, $urandom);
                    random_count++;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    n_adds = $urandom_range(1, 3);
                    for (int i = 0; i < n_adds; i++)
                        queue_item(tkbwn_pkg::OP_ADD, $urandom, pick_weight(zero_vertex));
                    queue_item(tkbwn_pkg::OP_NORM, $urandom, $urandom);
                    random_count += n_adds + 1;
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last transaction in, then for every result out
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_slot_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_slot_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
